@@ rtl/two_link_leg_inverse_kinematics_defines.svh @@
// assertion macros shared by the leg kinematics rtl
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_DEFINES_SVH

// property checked outside reset
`define TLL_CHECK(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("leg ik check failed");

// property checked at every edge, reset included
`define TLL_CHECK_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("leg ik reset check failed");

`endif

@@ rtl/tllik_pkg.sv @@
package tllik_pkg;

    localparam int LINK_W        = 15;
    localparam int SCALE_W       = 16;
    localparam int FRAC_W        = 30;
    localparam int CORDIC_STAGES = 20;
    localparam int VEC_W         = 33;
    localparam int ANGLE_W       = 25;

    localparam logic [LINK_W-1:0]  UPPER_LINK_RESET = 15'd2560;
    localparam logic [LINK_W-1:0]  LOWER_LINK_RESET = 15'd5120;
    localparam logic [LINK_W-1:0]  MIN_REACH_RESET  = 15'd2560;
    localparam logic [LINK_W-1:0]  MAX_REACH_RESET  = 15'd7424;
    localparam logic [SCALE_W-1:0] GEAR_SCALE_RESET = 16'd256;

    // 90 degrees in 2^-16 degree
    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [26:0] ANGLE_LIMIT  = 27'sd23040;

    typedef enum logic [2:0] {
        REG_UPPER_LINK = 3'd0,
        REG_LOWER_LINK = 3'd1,
        REG_MIN_REACH  = 3'd2,
        REG_MAX_REACH  = 3'd3,
        REG_GEAR_SCALE = 3'd4
    } cfg_reg_t;

    // rounded atan(2^-i) in 2^-16 degree
    function automatic logic signed [ANGLE_W-1:0] atan_deg16(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] a;
        case (idx)
            5'd0:    a = 25'sd2949120;
            5'd1:    a = 25'sd1740967;
            5'd2:    a = 25'sd919879;
            5'd3:    a = 25'sd466945;
            5'd4:    a = 25'sd234379;
            5'd5:    a = 25'sd117304;
            5'd6:    a = 25'sd58666;
            5'd7:    a = 25'sd29335;
            5'd8:    a = 25'sd14668;
            5'd9:    a = 25'sd7334;
            5'd10:   a = 25'sd3667;
            5'd11:   a = 25'sd1833;
            5'd12:   a = 25'sd917;
            5'd13:   a = 25'sd458;
            5'd14:   a = 25'sd229;
            5'd15:   a = 25'sd115;
            5'd16:   a = 25'sd57;
            5'd17:   a = 25'sd29;
            5'd18:   a = 25'sd14;
            5'd19:   a = 25'sd7;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/two_link_leg_inverse_kinematics.sv @@
// pipeline from s_ transfer to m_ result: 24 root cells, 30 divide cells, 31 root cells,
// 20 cordic cells and 10 single stages, every one a register
// throughput: one foot position per cycle; the whole chain advances together and
// holds only while a result sits in the output register and m_tready is low
// reset: aresetn synchronous, active low; clears all valid bits and loads the
// configuration registers with their default link lengths, reach bounds and scale
`include "two_link_leg_inverse_kinematics_defines.svh"

module two_link_leg_inverse_kinematics (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // foot_x [15:0], foot_z [31:16]
    input  logic [1:0]  s_tuser,   // leg_index [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // joint_angle_one [15:0], joint_angle_two [31:16],
                                   // motor_target_first [63:32], motor_target_second [95:64]
    output logic        m_tuser    // reach_clamped
);

    localparam int SQ_N  = 24;
    localparam int CO_N  = 31;
    localparam int DIV_N = tllik_pkg::FRAC_W;
    localparam int CS_N  = tllik_pkg::CORDIC_STAGES;
    localparam int VW    = tllik_pkg::VEC_W;
    localparam int AW    = tllik_pkg::ANGLE_W;

    // ---------------- configuration ----------------
    logic [14:0] upper_reg, lower_reg, min_reg, max_reg;
    logic [15:0] gear_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= tllik_pkg::UPPER_LINK_RESET;
            lower_reg <= tllik_pkg::LOWER_LINK_RESET;
            min_reg   <= tllik_pkg::MIN_REACH_RESET;
            max_reg   <= tllik_pkg::MAX_REACH_RESET;
            gear_reg  <= tllik_pkg::GEAR_SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (tllik_pkg::cfg_reg_t'(cfg_addr))
                tllik_pkg::REG_UPPER_LINK: upper_reg <= cfg_wdata[14:0];
                tllik_pkg::REG_LOWER_LINK: lower_reg <= cfg_wdata[14:0];
                tllik_pkg::REG_MIN_REACH:  min_reg   <= cfg_wdata[14:0];
                tllik_pkg::REG_MAX_REACH:  max_reg   <= cfg_wdata[14:0];
                tllik_pkg::REG_GEAR_SCALE: gear_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic ce;
    logic o_valid_reg;
    assign ce       = !o_valid_reg || m_tready;
    assign s_tready = ce;

    // ---------------- stage a: squares ----------------
    logic signed [15:0] in_x, in_z;
    logic signed [31:0] xsq_full, zsq_full;
    logic               a_valid_reg;
    logic [31:0]        a_xsq_reg, a_zsq_reg;
    logic signed [15:0] a_x_reg;
    logic [1:0]         a_leg_reg;

    assign in_x     = s_tdata[15:0];
    assign in_z     = s_tdata[31:16];
    assign xsq_full = in_x * in_x;
    assign zsq_full = in_z * in_z;

    // ---------------- stage a2: reach compare ----------------
    logic [31:0] a_sum;
    logic [29:0] min_sq, max_sq;
    logic        reach_low, reach_high;
    logic [16:0] x_ext, x_mag;
    logic        a2_valid_reg;
    logic [31:0] a2_sum_reg;
    logic [29:0] a2_side_reg;

    assign a_sum      = a_xsq_reg + a_zsq_reg;
    assign min_sq     = min_reg * min_reg;
    assign max_sq     = max_reg * max_reg;
    assign reach_low  = a_sum < {2'b00, min_sq};
    // the max bound is tested after the min clamp and wins over it
    assign reach_high = reach_low ? (min_reg > max_reg) : (a_sum > {2'b00, max_sq});
    assign x_ext      = {a_x_reg[15], a_x_reg};
    assign x_mag      = a_x_reg[15] ? (~x_ext + 17'd1) : x_ext;

    // ---------------- reach root chain ----------------
    logic        sq_valid [0:SQ_N];
    logic [47:0] sq_rad   [0:SQ_N];
    logic [25:0] sq_rem   [0:SQ_N];
    logic [23:0] sq_root  [0:SQ_N];
    logic [29:0] sq_side  [0:SQ_N];

    assign sq_valid[0] = a2_valid_reg;
    assign sq_rad[0]   = {a2_sum_reg, 16'h0000};
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = a2_side_reg;

    for (genvar gi = 0; gi < SQ_N; gi++) begin : g_reach_root
        tllik_isqrt_cell #(.ROOT_W(SQ_N), .SIDE_W(30)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(sq_valid[gi]), .in_rad(sq_rad[gi]), .in_rem(sq_rem[gi]),
            .in_root(sq_root[gi]), .in_side(sq_side[gi]),
            .out_valid(sq_valid[gi+1]), .out_rad(sq_rad[gi+1]), .out_rem(sq_rem[gi+1]),
            .out_root(sq_root[gi+1]), .out_side(sq_side[gi+1])
        );
    end

    // ---------------- stage b: reach select ----------------
    logic [23:0] lq_sel;
    logic        b_valid_reg;
    logic [23:0] b_lq_reg, b_xm_reg;
    logic [1:0]  b_leg_reg;
    logic        b_xneg_reg, b_clamped_reg;

    always_comb begin
        if (sq_side[SQ_N][27]) begin
            lq_sel = {1'b0, max_reg, 8'h00};
        end else if (sq_side[SQ_N][28]) begin
            lq_sel = {1'b0, min_reg, 8'h00};
        end else begin
            lq_sel = sq_root[SQ_N];
        end
    end

    // ---------------- stage c: products ----------------
    logic [22:0]        l1q, l2q;
    logic [45:0]        l1sq, l2sq;
    logic [46:0]        den_half;
    logic               c_valid_reg;
    logic [47:0]        c_lqsq_reg, c_den_reg;
    logic signed [46:0] c_diff_reg;
    logic               c_satu_reg;
    logic [23:0]        c_lq_reg, c_xm_reg;
    logic [1:0]         c_leg_reg;
    logic               c_xneg_reg, c_clamped_reg;

    assign l1q      = {upper_reg, 8'h00};
    assign l2q      = {lower_reg, 8'h00};
    assign l1sq     = l1q * l1q;
    assign l2sq     = l2q * l2q;
    assign den_half = l1q * b_lq_reg;

    // ---------------- stage d: acos numerator ----------------
    logic signed [48:0] num;
    logic [48:0]        num_mag;
    logic               d_valid_reg;
    logic [48:0]        d_mag_reg, d_den_reg;
    logic               d_numneg_reg, d_satv_reg, d_satu_reg;
    logic [24:0]        d_xm_reg, d_lq_reg;
    logic [1:0]         d_leg_reg;
    logic               d_xneg_reg, d_clamped_reg;

    assign num     = $signed({1'b0, c_lqsq_reg}) + $signed({{2{c_diff_reg[46]}}, c_diff_reg});
    assign num_mag = num[48] ? 49'(-num) : 49'(num);

    // ---------------- divider chains ----------------
    logic                         du_valid [0:DIV_N];
    logic [24:0]                  du_rem   [0:DIV_N];
    logic [24:0]                  du_den   [0:DIV_N];
    logic [tllik_pkg::FRAC_W-1:0] du_quo   [0:DIV_N];
    logic [3:0]                   du_side  [0:DIV_N];
    logic                         dv_valid [0:DIV_N];
    logic [48:0]                  dv_rem   [0:DIV_N];
    logic [48:0]                  dv_den   [0:DIV_N];
    logic [tllik_pkg::FRAC_W-1:0] dv_quo   [0:DIV_N];
    logic [2:0]                   dv_side  [0:DIV_N];

    assign du_valid[0] = d_valid_reg;
    assign du_rem[0]   = d_xm_reg;
    assign du_den[0]   = d_lq_reg;
    assign du_quo[0]   = '0;
    assign du_side[0]  = {d_satu_reg, d_xneg_reg, d_leg_reg};
    assign dv_valid[0] = d_valid_reg;
    assign dv_rem[0]   = d_mag_reg;
    assign dv_den[0]   = d_den_reg;
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = {d_clamped_reg, d_numneg_reg, d_satv_reg};

    for (genvar gi = 0; gi < DIV_N; gi++) begin : g_divide
        tllik_div_cell #(.RW(25), .SIDE_W(4)) u_div_u (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(du_valid[gi]), .in_rem(du_rem[gi]), .in_den(du_den[gi]),
            .in_quo(du_quo[gi]), .in_side(du_side[gi]),
            .out_valid(du_valid[gi+1]), .out_rem(du_rem[gi+1]), .out_den(du_den[gi+1]),
            .out_quo(du_quo[gi+1]), .out_side(du_side[gi+1])
        );
        tllik_div_cell #(.RW(49), .SIDE_W(3)) u_div_v (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(dv_valid[gi]), .in_rem(dv_rem[gi]), .in_den(dv_den[gi]),
            .in_quo(dv_quo[gi]), .in_side(dv_side[gi]),
            .out_valid(dv_valid[gi+1]), .out_rem(dv_rem[gi+1]), .out_den(dv_den[gi+1]),
            .out_quo(dv_quo[gi+1]), .out_side(dv_side[gi+1])
        );
    end

    // ---------------- stage e: signed sine / cosine arguments ----------------
    logic [30:0] um_sel, vm_sel;
    logic        e_valid_reg;
    logic [30:0] e_um_reg, e_vm_reg;
    logic        e_uneg_reg, e_vneg_reg, e_clamped_reg;
    logic [1:0]  e_leg_reg;

    // a quotient at or above one saturates to one
    assign um_sel = du_side[DIV_N][3] ? 31'h4000_0000 : {1'b0, du_quo[DIV_N]};
    assign vm_sel = dv_side[DIV_N][0] ? 31'h4000_0000 : {1'b0, dv_quo[DIV_N]};

    // ---------------- stage f: 1 - a^2 ----------------
    localparam logic [61:0] ONE_SQ = 62'h1000_0000_0000_0000;
    logic        f_valid_reg;
    logic [61:0] f_rad_u_reg, f_rad_v_reg;
    logic [34:0] f_side_u_reg;
    logic [31:0] f_side_v_reg;

    // ---------------- cosine root chains ----------------
    logic        cu_valid [0:CO_N];
    logic [61:0] cu_rad   [0:CO_N];
    logic [32:0] cu_rem   [0:CO_N];
    logic [30:0] cu_root  [0:CO_N];
    logic [34:0] cu_side  [0:CO_N];
    logic        cv_valid [0:CO_N];
    logic [61:0] cv_rad   [0:CO_N];
    logic [32:0] cv_rem   [0:CO_N];
    logic [30:0] cv_root  [0:CO_N];
    logic [31:0] cv_side  [0:CO_N];

    assign cu_valid[0] = f_valid_reg;
    assign cu_rad[0]   = f_rad_u_reg;
    assign cu_rem[0]   = '0;
    assign cu_root[0]  = '0;
    assign cu_side[0]  = f_side_u_reg;
    assign cv_valid[0] = f_valid_reg;
    assign cv_rad[0]   = f_rad_v_reg;
    assign cv_rem[0]   = '0;
    assign cv_root[0]  = '0;
    assign cv_side[0]  = f_side_v_reg;

    for (genvar gi = 0; gi < CO_N; gi++) begin : g_cos_root
        tllik_isqrt_cell #(.ROOT_W(CO_N), .SIDE_W(35)) u_root_u (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(cu_valid[gi]), .in_rad(cu_rad[gi]), .in_rem(cu_rem[gi]),
            .in_root(cu_root[gi]), .in_side(cu_side[gi]),
            .out_valid(cu_valid[gi+1]), .out_rad(cu_rad[gi+1]), .out_rem(cu_rem[gi+1]),
            .out_root(cu_root[gi+1]), .out_side(cu_side[gi+1])
        );
        tllik_isqrt_cell #(.ROOT_W(CO_N), .SIDE_W(32)) u_root_v (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(cv_valid[gi]), .in_rad(cv_rad[gi]), .in_rem(cv_rem[gi]),
            .in_root(cv_root[gi]), .in_side(cv_side[gi]),
            .out_valid(cv_valid[gi+1]), .out_rad(cv_rad[gi+1]), .out_rem(cv_rem[gi+1]),
            .out_root(cv_root[gi+1]), .out_side(cv_side[gi+1])
        );
    end

    // ---------------- cordic chains ----------------
    logic                 kp_valid [0:CS_N];
    logic signed [VW-1:0] kp_x     [0:CS_N];
    logic signed [VW-1:0] kp_y     [0:CS_N];
    logic signed [AW-1:0] kp_z     [0:CS_N];
    logic [2:0]           kp_side  [0:CS_N];
    logic                 kh_valid [0:CS_N];
    logic signed [VW-1:0] kh_x     [0:CS_N];
    logic signed [VW-1:0] kh_y     [0:CS_N];
    logic signed [AW-1:0] kh_z     [0:CS_N];
    logic [0:0]           kh_side  [0:CS_N];
    logic signed [VW-1:0] um_vec, vm_vec, cou_vec, cov_vec;
    logic                 uneg_end, vneg_end;

    assign um_vec   = {2'b00, cu_side[CO_N][30:0]};
    assign uneg_end = cu_side[CO_N][31];
    assign cou_vec  = {2'b00, cu_root[CO_N]};
    assign vm_vec   = {2'b00, cv_side[CO_N][30:0]};
    assign vneg_end = cv_side[CO_N][31];
    assign cov_vec  = {2'b00, cv_root[CO_N]};

    // psi = atan2(u, cos); phi = atan2(cos, v), turned by 90 degrees when v < 0
    assign kp_valid[0] = cu_valid[CO_N];
    assign kp_x[0]     = cou_vec;
    assign kp_y[0]     = uneg_end ? -um_vec : um_vec;
    assign kp_z[0]     = '0;
    assign kp_side[0]  = cu_side[CO_N][34:32];
    assign kh_valid[0] = cv_valid[CO_N];
    assign kh_x[0]     = vneg_end ? cov_vec : vm_vec;
    assign kh_y[0]     = vneg_end ? vm_vec : cov_vec;
    assign kh_z[0]     = '0;
    assign kh_side[0]  = vneg_end;

    for (genvar gi = 0; gi < CS_N; gi++) begin : g_cordic
        tllik_cordic_cell #(.STAGE(gi), .SIDE_W(3)) u_psi (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(kp_valid[gi]), .in_x(kp_x[gi]), .in_y(kp_y[gi]), .in_z(kp_z[gi]),
            .in_side(kp_side[gi]),
            .out_valid(kp_valid[gi+1]), .out_x(kp_x[gi+1]), .out_y(kp_y[gi+1]),
            .out_z(kp_z[gi+1]), .out_side(kp_side[gi+1])
        );
        tllik_cordic_cell #(.STAGE(gi), .SIDE_W(1)) u_phi (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(kh_valid[gi]), .in_x(kh_x[gi]), .in_y(kh_y[gi]), .in_z(kh_z[gi]),
            .in_side(kh_side[gi]),
            .out_valid(kh_valid[gi+1]), .out_x(kh_x[gi+1]), .out_y(kh_y[gi+1]),
            .out_z(kh_z[gi+1]), .out_side(kh_side[gi+1])
        );
    end

    // ---------------- stage g: joint angles ----------------
    function automatic logic signed [15:0] out_angle(input logic signed [26:0] a);
        logic signed [26:0] t;
        t = (a + 27'sd256) >>> 9;
        if (t > tllik_pkg::ANGLE_LIMIT) begin
            return 16'sd23040;
        end else if (t < -tllik_pkg::ANGLE_LIMIT) begin
            return -16'sd23040;
        end
        return t[15:0];
    endfunction

    logic signed [26:0] g_psi, g_phi, g_a1, g_a2;
    logic               g_valid_reg;
    logic signed [15:0] g_th1_reg, g_th2_reg;
    logic [1:0]         g_leg_reg;
    logic               g_clamped_reg;

    assign g_psi = 27'(kp_z[CS_N]);
    assign g_phi = 27'(kh_z[CS_N]) + (kh_side[CS_N][0] ? tllik_pkg::QUARTER_TURN : 27'sd0);
    assign g_a1  = g_phi + g_psi - tllik_pkg::QUARTER_TURN;
    assign g_a2  = g_phi - g_psi - tllik_pkg::QUARTER_TURN;

    // ---------------- stage h: gear products ----------------
    logic signed [16:0] gear_s;
    logic signed [32:0] h_p1, h_p2;
    logic               h_valid_reg;
    logic signed [32:0] h_p1_reg, h_p2_reg;
    logic signed [15:0] h_th1_reg, h_th2_reg;
    logic [1:0]         h_leg_reg;
    logic               h_clamped_reg;

    assign gear_s = $signed({1'b0, gear_reg});
    assign h_p1   = g_th1_reg * gear_s;
    assign h_p2   = g_th2_reg * gear_s;

    // ---------------- output stage: sign mapping and rounding ----------------
    logic               left_side;
    logic signed [33:0] src1, src2, mv1, mv2, rnd1, rnd2;
    logic [95:0]        o_data_reg;
    logic               o_user_reg;

    // legs 0 and 1 drive their motors mirrored and swapped
    assign left_side = !h_leg_reg[1];
    assign src1 = 34'(left_side ? h_p2_reg : h_p1_reg);
    assign src2 = 34'(left_side ? h_p1_reg : h_p2_reg);
    assign mv1  = left_side ? -src1 : src1;
    assign mv2  = left_side ? -src2 : src2;
    assign rnd1 = (mv1 + 34'sd16384) >>> 15;
    assign rnd2 = (mv2 + 34'sd16384) >>> 15;

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            a2_valid_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
            g_valid_reg  <= 1'b0;
            h_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (ce) begin
            a_valid_reg  <= s_tvalid;
            a2_valid_reg <= a_valid_reg;
            b_valid_reg  <= sq_valid[SQ_N];
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            e_valid_reg  <= du_valid[DIV_N];
            f_valid_reg  <= e_valid_reg;
            g_valid_reg  <= kp_valid[CS_N];
            h_valid_reg  <= g_valid_reg;
            o_valid_reg  <= h_valid_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (ce) begin
            a_xsq_reg <= xsq_full;
            a_zsq_reg <= zsq_full;
            a_x_reg   <= in_x;
            a_leg_reg <= s_tuser;

            a2_sum_reg  <= a_sum;
            a2_side_reg <= {reach_low || reach_high, reach_low && !reach_high, reach_high,
                            a_x_reg[15], a_leg_reg, x_mag[15:0], 8'h00};

            b_lq_reg      <= (lq_sel == '0) ? 24'd1 : lq_sel;
            b_xm_reg      <= sq_side[SQ_N][23:0];
            b_leg_reg     <= sq_side[SQ_N][25:24];
            b_xneg_reg    <= sq_side[SQ_N][26];
            b_clamped_reg <= sq_side[SQ_N][29];

            c_lqsq_reg    <= b_lq_reg * b_lq_reg;
            c_den_reg     <= {den_half, 1'b0};
            c_diff_reg    <= $signed({1'b0, l1sq}) - $signed({1'b0, l2sq});
            c_satu_reg    <= b_xm_reg >= b_lq_reg;
            c_lq_reg      <= b_lq_reg;
            c_xm_reg      <= b_xm_reg;
            c_leg_reg     <= b_leg_reg;
            c_xneg_reg    <= b_xneg_reg;
            c_clamped_reg <= b_clamped_reg;

            d_mag_reg     <= num_mag;
            d_den_reg     <= {1'b0, c_den_reg};
            d_numneg_reg  <= num[48];
            d_satv_reg    <= num_mag >= {1'b0, c_den_reg};
            d_satu_reg    <= c_satu_reg;
            d_xm_reg      <= {1'b0, c_xm_reg};
            d_lq_reg      <= {1'b0, c_lq_reg};
            d_leg_reg     <= c_leg_reg;
            d_xneg_reg    <= c_xneg_reg;
            d_clamped_reg <= c_clamped_reg;

            // a zero ratio keeps no sign
            e_um_reg      <= um_sel;
            e_vm_reg      <= vm_sel;
            e_uneg_reg    <= du_side[DIV_N][2] && (um_sel != '0);
            e_vneg_reg    <= dv_side[DIV_N][1] && (vm_sel != '0);
            e_leg_reg     <= du_side[DIV_N][1:0];
            e_clamped_reg <= dv_side[DIV_N][2];

            f_rad_u_reg  <= ONE_SQ - e_um_reg * e_um_reg;
            f_rad_v_reg  <= ONE_SQ - e_vm_reg * e_vm_reg;
            f_side_u_reg <= {e_leg_reg, e_clamped_reg, e_uneg_reg, e_um_reg};
            f_side_v_reg <= {e_vneg_reg, e_vm_reg};

            g_th1_reg     <= out_angle(g_a1);
            g_th2_reg     <= out_angle(g_a2);
            g_leg_reg     <= kp_side[CS_N][2:1];
            g_clamped_reg <= kp_side[CS_N][0];

            h_p1_reg      <= h_p1;
            h_p2_reg      <= h_p2;
            h_th1_reg     <= g_th1_reg;
            h_th2_reg     <= g_th2_reg;
            h_leg_reg     <= g_leg_reg;
            h_clamped_reg <= g_clamped_reg;

            o_data_reg <= {rnd2[31:0], rnd1[31:0], h_th2_reg, h_th1_reg};
            o_user_reg <= h_clamped_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

    logic signed [15:0] o_th1, o_th2;
    logic               o_range_ok;
    assign o_th1 = o_data_reg[15:0];
    assign o_th2 = o_data_reg[31:16];
    assign o_range_ok = o_th1 <= 16'sd23040 && o_th1 >= -16'sd23040 &&
                        o_th2 <= 16'sd23040 && o_th2 >= -16'sd23040;

    `TLL_CHECK(a_div_lanes_aligned, du_valid[DIV_N] == dv_valid[DIV_N])
    `TLL_CHECK(a_root_lanes_aligned, cu_valid[CO_N] == cv_valid[CO_N])
    `TLL_CHECK(a_cordic_lanes_aligned, kp_valid[CS_N] == kh_valid[CS_N])
    `TLL_CHECK(a_angle_range, m_tvalid |-> o_range_ok)
    `TLL_CHECK_RST(a_reset_empty, !aresetn |=> !m_tvalid)

endmodule

@@ rtl/tllik_isqrt_cell.sv @@
module tllik_isqrt_cell #(
    parameter int ROOT_W = 24,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [ROOT_W+1:0]     in_rem,
    input  logic [ROOT_W-1:0]     in_root,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [2*ROOT_W-1:0]   out_rad,
    output logic [ROOT_W+1:0]     out_rem,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    logic                valid_reg;
    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [ROOT_W+1:0]   rem_sh, trial;
    logic                fits;

    // one root bit per cell, two radicand bits brought down
    assign rem_sh    = {in_rem[ROOT_W-1:0], in_rad[2*ROOT_W-1 -: 2]};
    assign trial     = {in_root, 2'b01};
    assign fits      = rem_sh >= trial;
    assign rem_next  = fits ? rem_sh - trial : rem_sh;
    assign root_next = {in_root[ROOT_W-2:0], fits};
    assign rad_next  = {in_rad[2*ROOT_W-3:0], 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/tllik_div_cell.sv @@
module tllik_div_cell #(
    parameter int RW     = 25,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [RW-1:0]                in_rem,
    input  logic [RW-1:0]                in_den,
    input  logic [tllik_pkg::FRAC_W-1:0] in_quo,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [RW-1:0]                out_rem,
    output logic [RW-1:0]                out_den,
    output logic [tllik_pkg::FRAC_W-1:0] out_quo,
    output logic [SIDE_W-1:0]            out_side
);

    logic                         valid_reg;
    logic [RW-1:0]                rem_reg, rem_next, den_reg;
    logic [tllik_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [SIDE_W-1:0]            side_reg;
    logic [RW-1:0]                rem_sh;
    logic                         fits;

    // restoring step, one quotient bit per cell
    assign rem_sh   = {in_rem[RW-2:0], 1'b0};
    assign fits     = rem_sh >= in_den;
    assign rem_next = fits ? rem_sh - in_den : rem_sh;
    assign quo_next = {in_quo[tllik_pkg::FRAC_W-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/tllik_cordic_cell.sv @@
module tllik_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic signed [tllik_pkg::VEC_W-1:0]   in_x,
    input  logic signed [tllik_pkg::VEC_W-1:0]   in_y,
    input  logic signed [tllik_pkg::ANGLE_W-1:0] in_z,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic signed [tllik_pkg::VEC_W-1:0]   out_x,
    output logic signed [tllik_pkg::VEC_W-1:0]   out_y,
    output logic signed [tllik_pkg::ANGLE_W-1:0] out_z,
    output logic [SIDE_W-1:0]                    out_side
);

    logic                                 valid_reg;
    logic signed [tllik_pkg::VEC_W-1:0]   x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [tllik_pkg::ANGLE_W-1:0] z_reg, z_next, step_angle;
    logic [SIDE_W-1:0]                    side_reg;

    assign xs         = in_x >>> STAGE;
    assign ys         = in_y >>> STAGE;
    assign step_angle = tllik_pkg::atan_deg16(5'(STAGE));

    // vectoring: rotate toward y = 0
    always_comb begin
        if (!in_y[tllik_pkg::VEC_W-1]) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + step_angle;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - step_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule
